// ===== rtl/core/lfs_pkg.sv =====
`default_nettype none

package lfs_pkg;

    localparam int EXP_SEGMENTS_DEF = 64;

    localparam int DATA_W  = 32;
    localparam int Z_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int QUO_W   = 34;
    localparam int CNT_W   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VISCOUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COULOMB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BREAKAWAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIBECK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd6;

    localparam logic [31:0] RST_STIFFNESS = 32'd65536000;
    localparam logic [31:0] RST_DAMPING   = 32'd655360;
    localparam logic [31:0] RST_VISCOUS   = 32'd26214;
    localparam logic [31:0] RST_COULOMB   = 32'd65536;
    localparam logic [31:0] RST_BREAKAWAY = 32'd98304;
    localparam logic [31:0] RST_STRIBECK  = 32'd2684355;
    localparam logic [31:0] RST_PERIOD    = 32'd4294967;

    // tiny g threshold in q16.47 and bristle rate cap
    localparam logic [63:0]      G_MIN = 64'd1407374;
    localparam logic [QUO_W-1:0] Q_CAP = 34'h2_0000_0000;

    localparam logic [CNT_W-1:0] RATIO_BITS = 6'd18;
    localparam logic [CNT_W-1:0] QUO_BITS   = 6'd34;

    typedef struct packed {
        logic              start;
        logic [63:0]       rem_init;
        logic [QUO_W-1:0]  num_lo;
        logic [CNT_W-1:0]  nbits;
        logic [63:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUO_W-1:0]  quo;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfs_mul.sv =====
`default_nettype none

module lfs_mul (
    input  wire logic        aclk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [63:0]      p
);

    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lfs_div.sv =====
`default_nettype none

module lfs_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lfs_pkg::div_req_t req,
    output lfs_pkg::div_rsp_t      rsp
);

    logic [lfs_pkg::CNT_W-1:0] cnt_reg;
    logic                      done_reg;
    logic [63:0]               rem_reg;
    logic [63:0]               d_reg;
    logic [lfs_pkg::QUO_W-1:0] sh_reg;
    logic [lfs_pkg::QUO_W-1:0] quo_reg;

    logic [63:0] rem_t;
    logic        ge;
    logic [63:0] rem_next;

    always_comb begin
        rem_t    = {rem_reg[62:0], sh_reg[lfs_pkg::QUO_W-1]};
        ge       = (rem_t >= d_reg);
        rem_next = ge ? (rem_t - d_reg) : rem_t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == lfs_pkg::CNT_W'(1));
            if (req.start) begin
                cnt_reg <= req.nbits;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - lfs_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.rem_init;
            sh_reg  <= req.num_lo;
            d_reg   <= req.divisor;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[lfs_pkg::QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[lfs_pkg::QUO_W-2:0], ge};
        end
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lfs_exp_rom.sv =====
`default_nettype none

module lfs_exp_rom #(
    parameter int EXP_SEGMENTS = lfs_pkg::EXP_SEGMENTS_DEF,
    parameter int IW = $clog2(EXP_SEGMENTS + 1)
) (
    input  wire logic [IW-1:0] idx,
    output logic [31:0]        node_lo,
    output logic [31:0]        node_hi
);

    logic [31:0] tab [0:EXP_SEGMENTS];

    // node k = (e^-y)^256, y = k/(16*segments), taylor sum then eight squarings
    for (genvar k = 0; k <= EXP_SEGMENTS; k++) begin : g_node
        localparam logic [63:0] Y  = ((64'(k) << 27) + 64'(EXP_SEGMENTS / 2))
                                     / 64'(EXP_SEGMENTS);
        localparam logic [63:0] T0 = 64'h8000_0000;
        localparam logic [63:0] T1 = ((T0 * Y) >> 31) / 64'd1;
        localparam logic [63:0] T2 = ((T1 * Y) >> 31) / 64'd2;
        localparam logic [63:0] T3 = ((T2 * Y) >> 31) / 64'd3;
        localparam logic [63:0] T4 = ((T3 * Y) >> 31) / 64'd4;
        localparam logic [63:0] T5 = ((T4 * Y) >> 31) / 64'd5;
        localparam logic [63:0] T6 = ((T5 * Y) >> 31) / 64'd6;
        localparam logic [63:0] S0 = T0 - T1 + T2 - T3 + T4 - T5 + T6;
        localparam logic [63:0] S1 = (S0 * S0 + 64'h4000_0000) >> 31;
        localparam logic [63:0] S2 = (S1 * S1 + 64'h4000_0000) >> 31;
        localparam logic [63:0] S3 = (S2 * S2 + 64'h4000_0000) >> 31;
        localparam logic [63:0] S4 = (S3 * S3 + 64'h4000_0000) >> 31;
        localparam logic [63:0] S5 = (S4 * S4 + 64'h4000_0000) >> 31;
        localparam logic [63:0] S6 = (S5 * S5 + 64'h4000_0000) >> 31;
        localparam logic [63:0] S7 = (S6 * S6 + 64'h4000_0000) >> 31;
        localparam logic [63:0] S8 = (S7 * S7 + 64'h4000_0000) >> 31;
        assign tab[k] = S8[31:0];
    end

    logic [IW-1:0] idx_hi;

    assign idx_hi  = idx + IW'(1);
    assign node_lo = tab[idx];
    assign node_hi = tab[idx_hi];

endmodule

`default_nettype wire

// ===== rtl/core/lugre_friction_step.sv =====
// from accept to m_tvalid the run is shorter when the tiny-g guard fires, as it skips the bristle-rate divide
// the bit-serial divider runs 18 steps for v/vs and 34 steps for the bristle rate; either divide can be skipped
// a new item is taken only once the previous one has left S_DONE; s_tready is high only between items
// a finished item waits in the output register while the next one runs
// reset (aresetn low, synchronous) restores the config registers, returns to idle, drops m_tvalid and clears deflection

`default_nettype none

module lugre_friction_step #(
    parameter int EXP_SEGMENTS = lfs_pkg::EXP_SEGMENTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] joint_speed
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] friction_out
    output logic             m_tuser,   // [0] guard_taken
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    localparam int IW = $clog2(EXP_SEGMENTS + 1);
    localparam int PW = 20 + IW;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RCHK  = 5'd1;
    localparam logic [4:0] S_RDIV  = 5'd2;
    localparam logic [4:0] S_USQ   = 5'd3;
    localparam logic [4:0] S_UIDX  = 5'd4;
    localparam logic [4:0] S_TAB   = 5'd5;
    localparam logic [4:0] S_INTP  = 5'd6;
    localparam logic [4:0] S_INTP2 = 5'd7;
    localparam logic [4:0] S_GMUL  = 5'd8;
    localparam logic [4:0] S_GSUM  = 5'd9;
    localparam logic [4:0] S_GCHK  = 5'd10;
    localparam logic [4:0] S_AMUL  = 5'd11;
    localparam logic [4:0] S_PP0   = 5'd12;
    localparam logic [4:0] S_PP1   = 5'd13;
    localparam logic [4:0] S_PP2   = 5'd14;
    localparam logic [4:0] S_PP3   = 5'd15;
    localparam logic [4:0] S_PP4   = 5'd16;
    localparam logic [4:0] S_QCHK  = 5'd17;
    localparam logic [4:0] S_QDIV  = 5'd18;
    localparam logic [4:0] S_DZ    = 5'd19;
    localparam logic [4:0] S_STEP  = 5'd20;
    localparam logic [4:0] S_ZUPD  = 5'd21;
    localparam logic [4:0] S_ZMAG  = 5'd22;
    localparam logic [4:0] S_T0A   = 5'd23;
    localparam logic [4:0] S_T0B   = 5'd24;
    localparam logic [4:0] S_T0C   = 5'd25;
    localparam logic [4:0] S_T1    = 5'd26;
    localparam logic [4:0] S_T2    = 5'd27;
    localparam logic [4:0] S_SUM   = 5'd28;
    localparam logic [4:0] S_DONE  = 5'd29;

    logic [4:0] state_reg;

    logic [31:0] s0_reg, s1_reg, s2_reg, fc_reg, fs_reg, vs_reg, dt_reg;

    logic signed [lfs_pkg::Z_W-1:0] z_reg;
    logic [lfs_pkg::Z_W-1:0]        zmag_reg;
    logic signed [31:0]  v_reg;
    logic [31:0]         vmag_reg;
    logic [17:0]         r_reg;
    logic [IW-1:0]       idx_reg;
    logic [19:0]         frac_reg;
    logic [31:0]         node_reg;
    logic [31:0]         diff_reg;
    logic                desc_reg;
    logic [31:0]         e_reg;
    logic [63:0]         g_reg;
    logic [63:0]         a_reg;
    logic [111:0]        acc_reg;
    logic [lfs_pkg::QUO_W-1:0] q_reg;
    logic signed [31:0]  dz_reg;
    logic                guard_reg;
    logic [39:0]         t0_reg;
    logic [47:0]         t1_reg;
    logic [47:0]         t2_reg;
    logic signed [31:0]  tau_reg;

    logic                m_tvalid_reg;
    logic [31:0]         m_tdata_reg;
    logic                m_tuser_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] p;

    lfs_pkg::div_req_t div_req;
    lfs_pkg::div_rsp_t div_rsp;

    logic [31:0] node_lo, node_hi;

    lfs_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (p)
    );

    lfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lfs_exp_rom #(
        .EXP_SEGMENTS (EXP_SEGMENTS),
        .IW           (IW)
    ) u_rom (
        .idx     (idx_reg),
        .node_lo (node_lo),
        .node_hi (node_hi)
    );

    logic [31:0]  in_mag;
    logic [31:0]  seff;
    logic [31:0]  fdiff;
    logic [31:0]  dzmag;
    logic [PW-1:0] pos;
    logic [102:0] n_val;
    logic [lfs_pkg::Z_W-1:0] zabs;

    always_comb begin
        in_mag = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
        seff   = (vs_reg == '0) ? 32'd1 : vs_reg;
        fdiff  = (fs_reg >= fc_reg) ? (fs_reg - fc_reg) : (fc_reg - fs_reg);
        dzmag  = dz_reg[31] ? (~dz_reg + 32'd1) : dz_reg;
        pos    = PW'(p[35:16]) * PW'(EXP_SEGMENTS);
        n_val  = acc_reg[111:9];
        zabs   = z_reg[lfs_pkg::Z_W-1] ? (~z_reg + lfs_pkg::Z_W'(1)) : z_reg;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_USQ: begin
                mul_a = 32'(r_reg);
                mul_b = 32'(r_reg);
            end
            S_INTP: begin
                mul_a = diff_reg;
                mul_b = 32'(frac_reg);
            end
            S_GMUL: begin
                mul_a = fdiff;
                mul_b = e_reg;
            end
            S_AMUL: begin
                mul_a = s0_reg;
                mul_b = vmag_reg;
            end
            S_PP0: begin
                mul_a = p[31:0];
                mul_b = zmag_reg[31:0];
            end
            S_PP1: begin
                mul_a = a_reg[31:0];
                mul_b = 32'(zmag_reg[47:32]);
            end
            S_PP2: begin
                mul_a = a_reg[63:32];
                mul_b = zmag_reg[31:0];
            end
            S_PP3: begin
                mul_a = a_reg[63:32];
                mul_b = 32'(zmag_reg[47:32]);
            end
            S_STEP: begin
                mul_a = dzmag;
                mul_b = dt_reg;
            end
            S_T0A: begin
                mul_a = s0_reg;
                mul_b = zmag_reg[31:0];
            end
            S_T0B: begin
                mul_a = s0_reg;
                mul_b = 32'(zmag_reg[47:32]);
            end
            S_T0C: begin
                mul_a = s1_reg;
                mul_b = dzmag;
            end
            S_T1: begin
                mul_a = s2_reg;
                mul_b = vmag_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic ratio_big, quo_big;

    always_comb begin
        ratio_big = ({vmag_reg, 10'b0} >= {10'b0, seff});
        quo_big   = (n_val[102:34] >= {5'b0, g_reg});
        div_req   = '0;
        if (state_reg == S_RCHK && !ratio_big) begin
            div_req.start    = 1'b1;
            div_req.rem_init = {12'b0, vmag_reg, 20'b0} >> 10;
            div_req.num_lo   = '0;
            div_req.nbits    = lfs_pkg::RATIO_BITS;
            div_req.divisor  = 64'(seff);
        end else if (state_reg == S_QCHK && !quo_big) begin
            div_req.start    = 1'b1;
            div_req.rem_init = n_val[97:34];
            div_req.num_lo   = n_val[33:0];
            div_req.nbits    = lfs_pkg::QUO_BITS;
            div_req.divisor  = g_reg;
        end
    end

    logic [63:0]        fc_sh;
    logic signed [35:0] dz_wide;
    logic signed [57:0] z_wide;
    logic [79:0]        t0_sum;
    logic signed [51:0] tau_wide;
    logic signed [51:0] t0s, t1s, t2s;

    always_comb begin
        fc_sh   = {1'b0, fc_reg, 31'b0};
        dz_wide = z_reg[lfs_pkg::Z_W-1]
                ? (36'(v_reg) + $signed({2'b0, q_reg}))
                : (36'(v_reg) - $signed({2'b0, q_reg}));
        z_wide  = dz_reg[31]
                ? (58'(z_reg) - $signed({2'b0, p[63:8]}))
                : (58'(z_reg) + $signed({2'b0, p[63:8]}));
        t0_sum  = acc_reg[79:0] + {p[47:0], 32'b0};
        t0s = z_reg[lfs_pkg::Z_W-1] ? -$signed(52'(t0_reg)) : $signed(52'(t0_reg));
        t1s = dz_reg[31] ? -$signed(52'(t1_reg)) : $signed(52'(t1_reg));
        t2s = v_reg[31] ? -$signed(52'(t2_reg)) : $signed(52'(t2_reg));
        tau_wide = t0s + t1s + t2s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg <= lfs_pkg::RST_STIFFNESS;
            s1_reg <= lfs_pkg::RST_DAMPING;
            s2_reg <= lfs_pkg::RST_VISCOUS;
            fc_reg <= lfs_pkg::RST_COULOMB;
            fs_reg <= lfs_pkg::RST_BREAKAWAY;
            vs_reg <= lfs_pkg::RST_STRIBECK;
            dt_reg <= lfs_pkg::RST_PERIOD;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lfs_pkg::REG_STIFFNESS: s0_reg <= cfg_wdata;
                lfs_pkg::REG_DAMPING:   s1_reg <= cfg_wdata;
                lfs_pkg::REG_VISCOUS:   s2_reg <= cfg_wdata;
                lfs_pkg::REG_COULOMB:   fc_reg <= cfg_wdata;
                lfs_pkg::REG_BREAKAWAY: fs_reg <= cfg_wdata;
                lfs_pkg::REG_STRIBECK:  vs_reg <= cfg_wdata;
                lfs_pkg::REG_PERIOD:    dt_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            z_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        v_reg     <= s_tdata;
                        vmag_reg  <= in_mag;
                        state_reg <= S_RCHK;
                    end
                end
                S_RCHK: begin
                    if (ratio_big) begin
                        e_reg     <= '0;
                        state_reg <= S_GMUL;
                    end else begin
                        state_reg <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (div_rsp.done) begin
                        r_reg     <= div_rsp.quo[17:0];
                        state_reg <= S_USQ;
                    end
                end
                S_USQ: state_reg <= S_UIDX;
                S_UIDX: begin
                    idx_reg   <= pos[PW-1:20];
                    frac_reg  <= pos[19:0];
                    state_reg <= S_TAB;
                end
                S_TAB: begin
                    node_reg  <= node_lo;
                    desc_reg  <= (node_lo >= node_hi);
                    diff_reg  <= (node_lo >= node_hi) ? (node_lo - node_hi)
                                                      : (node_hi - node_lo);
                    state_reg <= S_INTP;
                end
                S_INTP: state_reg <= S_INTP2;
                S_INTP2: begin
                    e_reg     <= desc_reg ? (node_reg - p[51:20]) : (node_reg + p[51:20]);
                    state_reg <= S_GMUL;
                end
                S_GMUL: state_reg <= S_GSUM;
                S_GSUM: begin
                    g_reg     <= (fs_reg >= fc_reg) ? (fc_sh + p) : (fc_sh - p);
                    state_reg <= S_GCHK;
                end
                S_GCHK: begin
                    zmag_reg <= zabs;
                    if (g_reg <= lfs_pkg::G_MIN) begin
                        dz_reg    <= v_reg;
                        guard_reg <= 1'b1;
                        state_reg <= S_STEP;
                    end else begin
                        guard_reg <= 1'b0;
                        state_reg <= S_AMUL;
                    end
                end
                S_AMUL: state_reg <= S_PP0;
                S_PP0: begin
                    a_reg     <= p;
                    state_reg <= S_PP1;
                end
                S_PP1: begin
                    acc_reg   <= 112'(p);
                    state_reg <= S_PP2;
                end
                S_PP2: begin
                    acc_reg   <= acc_reg + 112'({p, 32'b0});
                    state_reg <= S_PP3;
                end
                S_PP3: begin
                    acc_reg   <= acc_reg + 112'({p, 32'b0});
                    state_reg <= S_PP4;
                end
                S_PP4: begin
                    acc_reg   <= acc_reg + {p[47:0], 64'b0};
                    state_reg <= S_QCHK;
                end
                S_QCHK: begin
                    if (quo_big) begin
                        q_reg     <= lfs_pkg::Q_CAP;
                        state_reg <= S_DZ;
                    end else begin
                        state_reg <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (div_rsp.done) begin
                        q_reg     <= (div_rsp.quo > lfs_pkg::Q_CAP) ? lfs_pkg::Q_CAP
                                                                   : div_rsp.quo;
                        state_reg <= S_DZ;
                    end
                end
                S_DZ: begin
                    if (dz_wide > 36'sd2147483647) begin
                        dz_reg <= 32'sh7FFF_FFFF;
                    end else if (dz_wide < -36'sd2147483648) begin
                        dz_reg <= 32'sh8000_0000;
                    end else begin
                        dz_reg <= dz_wide[31:0];
                    end
                    state_reg <= S_STEP;
                end
                S_STEP: state_reg <= S_ZUPD;
                S_ZUPD: begin
                    if (z_wide > 58'sd140737488355327) begin
                        z_reg <= 48'sh7FFF_FFFF_FFFF;
                    end else if (z_wide < -58'sd140737488355328) begin
                        z_reg <= 48'sh8000_0000_0000;
                    end else begin
                        z_reg <= z_wide[47:0];
                    end
                    state_reg <= S_ZMAG;
                end
                S_ZMAG: begin
                    zmag_reg  <= zabs;
                    state_reg <= S_T0A;
                end
                S_T0A: state_reg <= S_T0B;
                S_T0B: begin
                    acc_reg   <= 112'(p);
                    state_reg <= S_T0C;
                end
                S_T0C: begin
                    t0_reg    <= t0_sum[79:40];
                    state_reg <= S_T1;
                end
                S_T1: begin
                    t1_reg    <= p[63:16];
                    state_reg <= S_T2;
                end
                S_T2: begin
                    t2_reg    <= p[63:16];
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    if (tau_wide > 52'sd2147483647) begin
                        tau_reg <= 32'sh7FFF_FFFF;
                    end else if (tau_wide < -52'sd2147483648) begin
                        tau_reg <= 32'sh8000_0000;
                    end else begin
                        tau_reg <= tau_wide[31:0];
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= tau_reg;
                        m_tuser_reg  <= guard_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == S_RDIV || state_reg == S_QDIV))
        else $error("divider busy outside a divide state");

    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tready && state_reg != S_DONE) |=> !m_tvalid_reg)
        else $error("taken item not cleared from output register");

    a_z_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && state_reg != S_ZUPD) |=> (z_reg == $past(z_reg)))
        else $error("deflection changed outside its update step");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_RCHK && !div_rsp.busy))
        else $error("item accepted while work in flight");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/lugre_friction_step_test.sv =====
`default_nettype none

module lugre_friction_step_test;

    localparam int SEGS = lfs_pkg::EXP_SEGMENTS_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0] torque;
        logic        guard;
    } friction_t;

    typedef struct {
        logic [31:0] speed;
        bit          typed;
        logic [31:0] torque;
        logic        guard;
    } speed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    always #6 aclk = ~aclk;

    lugre_friction_step DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // model state
    logic [31:0] exp_nodes [0:SEGS];
    logic [63:0] sigma0, sigma1, sigma2, fc, fs, vs, dt;
    longint      z_model;
    friction_t   torque_due[$];
    int          errors = 0;
    bit          running = 1'b0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int          idle_cnt = 0;

    function automatic void build_exp_nodes();
        logic [63:0] y, term, s;
        longint sum;
        for (int k = 0; k <= SEGS; k++) begin
            y = ((64'(k) << 27) + 64'(SEGS / 2)) / 64'(SEGS);
            term = 64'd1 << 31;
            sum = longint'(term);
            for (int i = 1; i <= 6; i++) begin
                term = ((term * y) >> 31) / 64'(i);
                if (i % 2) sum -= longint'(term);
                else sum += longint'(term);
            end
            s = 64'(sum);
            for (int i = 0; i < 8; i++) s = (s * s + (64'd1 << 30)) >> 31;
            exp_nodes[k] = s[31:0];
        end
    endfunction

    function automatic logic [63:0] stribeck_exp(logic [63:0] vmag);
        logic [63:0] s, r, u, pos, idx, frac, a, b;
        s = (vs != 0) ? vs : 64'd1;
        r = (vmag << 28) / s;
        if (r >= (64'd4 << 16)) return 64'd0;
        u = (r * r) >> 16;
        if (u >= (64'd16 << 16)) return 64'd0;
        pos = u * 64'(SEGS);
        idx = pos >> 20;
        frac = pos & ((64'd1 << 20) - 64'd1);
        if (idx >= 64'(SEGS)) return 64'd0;
        a = 64'(exp_nodes[idx]);
        b = 64'(exp_nodes[idx + 64'd1]);
        if (a >= b) return a - (((a - b) * frac) >> 20);
        return a + (((b - a) * frac) >> 20);
    endfunction

    function automatic longint clamp(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic friction_t friction_predict(logic [31:0] raw);
        longint v, dz, q, step, t0, t1, t2, tau;
        logic [63:0] vmag, e, g, zmag, dzmag;
        logic [127:0] num;
        friction_t res;
        v = longint'(signed'(raw));
        vmag = v < 0 ? 64'(-v) : 64'(v);
        e = stribeck_exp(vmag);
        if (fs >= fc) g = (fc << 31) + (fs - fc) * e;
        else g = (fc << 31) - (fc - fs) * e;
        zmag = z_model < 0 ? 64'(-z_model) : 64'(z_model);
        res.guard = 1'b0;
        if (g <= lfs_pkg::G_MIN) begin
            dz = v;
            res.guard = 1'b1;
        end else begin
            num = (128'(sigma0 * vmag) * 128'(zmag)) >> 9;
            num = num / 128'(g);
            q = (num > 128'(lfs_pkg::Q_CAP)) ? longint'(64'(lfs_pkg::Q_CAP))
                                             : longint'(num[63:0]);
            dz = clamp(z_model < 0 ? v + q : v - q, -64'sd2147483648, 64'sd2147483647);
        end
        dzmag = dz < 0 ? 64'(-dz) : 64'(dz);
        step = longint'((dzmag * dt) >> 8);
        z_model = clamp(dz < 0 ? z_model - step : z_model + step,
                        -(longint'(1) <<< 47), (longint'(1) <<< 47) - 1);
        zmag = z_model < 0 ? 64'(-z_model) : 64'(z_model);
        num = (128'(sigma0) * 128'(zmag)) >> 40;
        t0 = longint'(num[63:0]);
        t1 = longint'((sigma1 * dzmag) >> 16);
        t2 = longint'((sigma2 * vmag) >> 16);
        tau = (z_model < 0 ? -t0 : t0) + (dz < 0 ? -t1 : t1) + (v < 0 ? -t2 : t2);
        tau = clamp(tau, -64'sd2147483648, 64'sd2147483647);
        res.torque = tau[31:0];
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // write all seven registers back to back, main process sits at a rising edge
    task automatic load_params(logic [31:0] p [7]);
        logic [2:0] idx;
        while (torque_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        for (int i = 0; i < 7; i++) begin
            idx = 3'(i);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= p[i];
            case (idx)
                lfs_pkg::REG_STIFFNESS: sigma0 = 64'(p[i]);
                lfs_pkg::REG_DAMPING:   sigma1 = 64'(p[i]);
                lfs_pkg::REG_VISCOUS:   sigma2 = 64'(p[i]);
                lfs_pkg::REG_COULOMB:   fc = 64'(p[i]);
                lfs_pkg::REG_BREAKAWAY: fs = 64'(p[i]);
                lfs_pkg::REG_STRIBECK:  vs = 64'(p[i]);
                lfs_pkg::REG_PERIOD:    dt = 64'(p[i]);
                default: ;
            endcase
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_speed(logic [31:0] v, bit typed, friction_t want);
        int gap;
        friction_t pred;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
        pred = friction_predict(v);
        torque_due.push_back(typed ? want : pred);
    endtask

    function automatic logic [31:0] rand_speed();
        case ($urandom_range(0, 3))
            0: return 32'($signed($urandom_range(0, 8191)) - 4096);
            1: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            2: return 32'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_param();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 200000);
            default: return $urandom;
        endcase
    endfunction

    // result side
    initial begin
        friction_t want;
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (torque_due.size() == 0) begin
                report("unexpected item", m_tdata, 32'h0);
            end else begin
                want = torque_due.pop_front();
                if (m_tdata !== want.torque) report("friction_out", m_tdata, want.torque);
                if (m_tuser !== want.guard) report("guard_taken", 32'(m_tuser), 32'(want.guard));
            end
        end
    end

    always @(posedge aclk) begin
        if (running) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
            else idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        speed_row_t rows [$];
        logic [31:0] p [7];
        logic [31:0] dir [14];
        logic [31:0] tiny [5];
        friction_t want;
        build_exp_nodes();
        sigma0 = 64'(lfs_pkg::RST_STIFFNESS);
        sigma1 = 64'(lfs_pkg::RST_DAMPING);
        sigma2 = 64'(lfs_pkg::RST_VISCOUS);
        fc = 64'(lfs_pkg::RST_COULOMB);
        fs = 64'(lfs_pkg::RST_BREAKAWAY);
        vs = 64'(lfs_pkg::RST_STRIBECK);
        dt = 64'(lfs_pkg::RST_PERIOD);
        z_model = 0;
        want = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        running = 1'b1;

        // zero speed from reset gives zero torque
        rows.push_back('{32'd0, 1'b1, 32'd0, 1'b0});
        dir = '{32'd1, 32'hFFFF_FFFF, 32'd655, 32'd2621, 32'd2622,
                32'hFFFF_F5C2, 32'd65536, 32'hFFFF_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd3000,
                32'd3000, 32'hFFFF_F448};
        foreach (dir[i]) rows.push_back('{dir[i], 1'b0, 32'd0, 1'b0});
        foreach (rows[i]) begin
            want.torque = rows[i].torque;
            want.guard = rows[i].guard;
            send_speed(rows[i].speed, rows[i].typed, want);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        // tiny g: no friction levels
        p = '{lfs_pkg::RST_STIFFNESS, lfs_pkg::RST_DAMPING, lfs_pkg::RST_VISCOUS,
              32'd0, 32'd0, lfs_pkg::RST_STRIBECK, lfs_pkg::RST_PERIOD};
        load_params(p);
        tiny = '{32'd100, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 32'hFFFF_FF00};
        foreach (tiny[i]) send_speed(tiny[i], 1'b0, want);
        s_tvalid <= 1'b0;
        @(posedge aclk);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: p = '{lfs_pkg::RST_STIFFNESS, lfs_pkg::RST_DAMPING, lfs_pkg::RST_VISCOUS,
                         lfs_pkg::RST_COULOMB, lfs_pkg::RST_BREAKAWAY,
                         lfs_pkg::RST_STRIBECK, lfs_pkg::RST_PERIOD};
                1: p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                2: p = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
                3: p = '{lfs_pkg::RST_STIFFNESS, lfs_pkg::RST_DAMPING, lfs_pkg::RST_VISCOUS,
                         32'd200000, 32'd1000, 32'd0, 32'hFFFF_FFFF};
                default: foreach (p[i]) p[i] = rand_param();
            endcase
            load_params(p);
            idle_on = (phase != 4);
            if (phase == 5) hold_req = 1'b1;
            for (int n = 0; n < 178; n++) send_speed(rand_speed(), 1'b0, want);
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end

        while (torque_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        running = 1'b0;
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/lfs_pkg.sv
rtl/core/lfs_mul.sv
rtl/core/lfs_div.sv
rtl/core/lfs_exp_rom.sv
rtl/core/lugre_friction_step.sv
tb/sv/lugre_friction_step_test.sv
